### rtl/core/mcd_pkg.sv
`timescale 1ns / 1ps
// Package for the matching pair cycle decomposition block.
// Holds sizes, item and memory port types and the walker state codes; no dependencies.
package mcd_pkg;

  localparam int VERTICES = 18;
  localparam int ADDR_W   = $clog2(VERTICES);
  localparam int CNT_W    = $clog2(VERTICES + 1);
  localparam int VERT_W   = 5;
  localparam int CYC_W    = 4;
  localparam int POS_W    = 5;
  localparam int LEN_W    = 5;

  typedef logic [VERT_W-1:0] vert_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    vert_t vertex;
    vert_t partner_first;
    vert_t partner_second;
    logic  last;
  } in_item_t;

  typedef struct packed {
    vert_t             cycle_vertex;
    logic [CYC_W-1:0]  cycle_number;
    logic [POS_W-1:0]  position;
    logic              cycle_end;
    logic [LEN_W-1:0]  cycle_length;
    logic [CYC_W-1:0]  cycle_count;
    logic              final_res;
    logic              error;
  } out_item_t;

  typedef struct packed {
    vert_t first;
    vert_t second;
  } entry_t;

  typedef struct packed {
    logic   wr_en;
    addr_t  wr_addr;
    entry_t wr_data;
    logic   rd_en;
    addr_t  rd_addr;
  } mem_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WALK
  } walk_state_t;

endpackage

### rtl/core/mcd_match_mem.sv
`timescale 1ns / 1ps
// Partner table: one entry per vertex holding both matchings' partners.
// One write and one registered read port; uses mcd_pkg.
module mcd_match_mem (
  input  logic              clk,
  input  mcd_pkg::mem_req_t req,
  output mcd_pkg::entry_t   rd_data
);

  mcd_pkg::entry_t mem [mcd_pkg::VERTICES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

### rtl/core/mcd_walker.sv
`timescale 1ns / 1ps
// Load control, start vertex scan and alternating walk with the result register.
// Drives the partner table through mcd_pkg::mem_req_t; uses mcd_pkg.
module mcd_walker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mcd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mcd_pkg::out_item_t out_data,
  output mcd_pkg::mem_req_t  mem_req,
  input  mcd_pkg::entry_t    rd_data
);

  mcd_pkg::walk_state_t             state_r, state_nxt;
  logic [mcd_pkg::VERTICES-1:0]     visited_r, visited_nxt;
  mcd_pkg::addr_t                   scan_r, scan_nxt;
  mcd_pkg::addr_t                   start_r, start_nxt;
  mcd_pkg::vert_t                   cur_r, cur_nxt;
  logic                             phase_r, phase_nxt;
  logic [mcd_pkg::POS_W-1:0]        pos_r, pos_nxt;
  logic [mcd_pkg::CYC_W-1:0]        cyc_r, cyc_nxt;
  logic [mcd_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                             out_valid_r, out_valid_nxt;
  mcd_pkg::out_item_t               out_r, out_nxt;

  logic                             step_en;
  mcd_pkg::vert_t                   next_v;
  logic                             next_bad;
  logic [mcd_pkg::CNT_W-1:0]        cnt_inc;
  logic                             cap_hit;
  logic [mcd_pkg::VERTICES-1:0]     marks;
  logic                             all_vis;
  logic [mcd_pkg::POS_W-1:0]        pos_inc;
  logic [mcd_pkg::CYC_W-1:0]        cyc_inc;

  assign in_ready  = (state_r == mcd_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mcd_pkg::ST_IDLE;
      visited_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      visited_r   <= visited_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scan_r  <= scan_nxt;
    start_r <= start_nxt;
    cur_r   <= cur_nxt;
    phase_r <= phase_nxt;
    pos_r   <= pos_nxt;
    cyc_r   <= cyc_nxt;
    cnt_r   <= cnt_nxt;
    out_r   <= out_nxt;
  end

  always_comb begin
    step_en  = !out_valid_r || out_ready;
    next_v   = phase_r ? rd_data.second : rd_data.first;
    next_bad = (int'(next_v) >= mcd_pkg::VERTICES);
    cnt_inc  = cnt_r + 1'b1;
    cap_hit  = (cnt_inc >= mcd_pkg::CNT_W'(mcd_pkg::VERTICES));
    marks    = visited_r | (mcd_pkg::VERTICES'(1) << cur_r);
    all_vis  = &marks;
    pos_inc  = pos_r + 1'b1;
    cyc_inc  = cyc_r + 1'b1;

    state_nxt     = state_r;
    visited_nxt   = visited_r;
    scan_nxt      = scan_r;
    start_nxt     = start_r;
    cur_nxt       = cur_r;
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    cyc_nxt       = cyc_r;
    cnt_nxt       = cnt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_req       = '0;

    unique case (state_r)
      mcd_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (int'(in_data.vertex) < mcd_pkg::VERTICES) begin
            mem_req.wr_en          = 1'b1;
            mem_req.wr_addr        = in_data.vertex[mcd_pkg::ADDR_W-1:0];
            mem_req.wr_data.first  = in_data.partner_first;
            mem_req.wr_data.second = in_data.partner_second;
          end
          if (in_data.last) begin
            visited_nxt = '0;
            cyc_nxt     = '0;
            cnt_nxt     = '0;
            scan_nxt    = '0;
            state_nxt   = mcd_pkg::ST_SCAN;
          end
        end
      end
      mcd_pkg::ST_SCAN: begin
        if (!visited_r[scan_r]) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = scan_r;
          start_nxt       = scan_r;
          cur_nxt         = mcd_pkg::VERT_W'(scan_r);
          phase_nxt       = 1'b0;
          pos_nxt         = '0;
          state_nxt       = mcd_pkg::ST_WALK;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      mcd_pkg::ST_WALK: begin
        if (step_en) begin
          out_valid_nxt        = 1'b1;
          out_nxt              = '0;
          out_nxt.cycle_vertex = cur_r;
          out_nxt.cycle_number = cyc_r;
          out_nxt.position     = pos_r;
          visited_nxt          = marks;
          cnt_nxt              = cnt_inc;
          pos_nxt              = pos_inc;
          if (next_bad || (!phase_r && cap_hit)) begin
            out_nxt.final_res   = 1'b1;
            out_nxt.error       = 1'b1;
            out_nxt.cycle_count = cyc_r;
            state_nxt           = mcd_pkg::ST_IDLE;
          end else if (phase_r && (next_v == mcd_pkg::VERT_W'(start_r))) begin
            out_nxt.cycle_end    = 1'b1;
            out_nxt.cycle_length = mcd_pkg::LEN_W'(pos_inc);
            cyc_nxt              = cyc_inc;
            if (cap_hit || all_vis) begin
              out_nxt.final_res   = 1'b1;
              out_nxt.error       = !all_vis;
              out_nxt.cycle_count = cyc_inc;
              state_nxt           = mcd_pkg::ST_IDLE;
            end else begin
              scan_nxt  = start_r + 1'b1;
              state_nxt = mcd_pkg::ST_SCAN;
            end
          end else if (phase_r && cap_hit) begin
            out_nxt.final_res   = 1'b1;
            out_nxt.error       = 1'b1;
            out_nxt.cycle_count = cyc_r;
            state_nxt           = mcd_pkg::ST_IDLE;
          end else begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = next_v[mcd_pkg::ADDR_W-1:0];
            cur_nxt         = next_v;
            phase_nxt       = !phase_r;
          end
        end
      end
      default: begin
        state_nxt = mcd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/matching_pair_cycle_decomposition_top.sv
`timescale 1ns / 1ps
// Idle, it takes one item per cycle; the item marked last starts the walk over the table.
// After the last item the walker passes the scan state; the walk state registers the first
// result, then one per cycle while the output is not stalled and no new start is scanned.
// Each new cycle begins in the scan state, which steps over visited start candidates.
// Reset clears the walker control and visited marks; the partner table is not cleared.
// Top level: partner table memory and walker; uses mcd_pkg, mcd_match_mem, mcd_walker.
module matching_pair_cycle_decomposition_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mcd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mcd_pkg::out_item_t out_data
);

  mcd_pkg::mem_req_t mem_req;
  mcd_pkg::entry_t   rd_data;

  mcd_match_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  mcd_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

endmodule

### rtl/core/mcd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the top level, attached by the bind below.
// Depends on mcd_pkg and matching_pair_cycle_decomposition_top.
module mcd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input mcd_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input mcd_pkg::out_item_t out_data
);

  logic [mcd_pkg::POS_W-1:0] pos_plus;
  logic                      load_seen;

  assign pos_plus  = out_data.position + 1'b1;
  assign load_seen = in_valid && in_data.last;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Result item changed while stalled.");

  a_idle_final: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_data.final_res)
    else $error("Loads accepted while a run still has results pending.");

  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.cycle_end |-> out_data.cycle_length == pos_plus)
    else $error("Cycle length does not match the closing position.");

  a_err_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error |-> out_data.final_res)
    else $error("Error flag on a result that is not final.");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    load_seen && in_ready |=> !in_ready)
    else $error("Block stayed ready after the last item was accepted.");

endmodule

bind matching_pair_cycle_decomposition_top mcd_checker u_mcd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### tb/matching_pair_cycle_decomposition_top_tb.sv
`timescale 1ns / 1ps
// Testbench for matching_pair_cycle_decomposition_top: loads matching pairs, predicts each walk.
// Depends on mcd_pkg and the top level; a scoreboard class holds the tables and expected items.
module matching_pair_cycle_decomposition_top_tb;

  localparam int LIMIT        = 200000;
  localparam int RANDOM_ITEMS = 220;
  localparam int VERTICES     = mcd_pkg::VERTICES;

  class cycle_walk_book;
    mcd_pkg::vert_t     first_tab[VERTICES];
    mcd_pkg::vert_t     second_tab[VERTICES];
    mcd_pkg::out_item_t walk_q[$];
    int                 fail_count;

    function new();
      fail_count = 0;
    endfunction

    function mcd_pkg::out_item_t place(int v, int cyc, int pos);
      mcd_pkg::out_item_t r;
      r = '0;
      r.cycle_vertex = mcd_pkg::VERT_W'(v);
      r.cycle_number = mcd_pkg::CYC_W'(cyc);
      r.position = mcd_pkg::POS_W'(pos);
      return r;
    endfunction

    function void walk_tables();
      mcd_pkg::out_item_t  res[VERTICES];
      logic [VERTICES-1:0] seen;
      int                  n, cur, nxt, pos, cycles;
      bit                  cut, err;
      seen = '0;
      n = 0;
      cycles = 0;
      cut = 0;
      err = 0;
      for (int s = 0; s < VERTICES && !cut; s++) begin
        if (seen[s]) continue;
        cur = s;
        pos = 0;
        forever begin
          res[n] = place(cur, cycles, pos);
          seen[cur] = 1'b1;
          n++;
          pos++;
          nxt = int'(first_tab[cur]);
          if (nxt >= VERTICES || n >= VERTICES) begin
            cut = 1;
            err = 1;
            break;
          end
          cur = nxt;
          res[n] = place(cur, cycles, pos);
          seen[cur] = 1'b1;
          n++;
          pos++;
          nxt = int'(second_tab[cur]);
          if (nxt >= VERTICES) begin
            cut = 1;
            err = 1;
            break;
          end
          if (nxt == s) begin
            res[n-1].cycle_end = 1'b1;
            res[n-1].cycle_length = mcd_pkg::LEN_W'(pos);
            cycles++;
            break;
          end
          if (n >= VERTICES) begin
            cut = 1;
            err = 1;
            break;
          end
          cur = nxt;
        end
        if (!cut && n >= VERTICES) begin
          cut = 1;
          err = (seen != '1);
        end
      end
      res[n-1].cycle_count = mcd_pkg::CYC_W'(cycles);
      res[n-1].final_res = 1'b1;
      res[n-1].error = err;
      for (int i = 0; i < n; i++) walk_q = {walk_q, res[i]};
    endfunction

    function void note_item(mcd_pkg::in_item_t it);
      if (it.vertex < VERTICES) begin
        first_tab[it.vertex] = it.partner_first;
        second_tab[it.vertex] = it.partner_second;
      end
      if (it.last) walk_tables();
    endfunction

    function void field_check(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(mcd_pkg::out_item_t got);
      mcd_pkg::out_item_t want;
      if (walk_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, got %h", $time, got);
        fail_count++;
        return;
      end
      want = walk_q.pop_front();
      field_check("cycle_vertex", int'(want.cycle_vertex), int'(got.cycle_vertex));
      field_check("cycle_number", int'(want.cycle_number), int'(got.cycle_number));
      field_check("position", int'(want.position), int'(got.position));
      field_check("cycle_end", int'(want.cycle_end), int'(got.cycle_end));
      field_check("cycle_length", int'(want.cycle_length), int'(got.cycle_length));
      field_check("cycle_count", int'(want.cycle_count), int'(got.cycle_count));
      field_check("final_res", int'(want.final_res), int'(got.final_res));
      field_check("error", int'(want.error), int'(got.error));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  mcd_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  mcd_pkg::out_item_t out_data;

  cycle_walk_book book;
  int send_idle_pct;
  int recv_idle_pct;
  int loaded_items;
  int cycle_cnt;

  always #10 clk = ~clk;

  matching_pair_cycle_decomposition_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) book.check_result(out_data);
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_item(input int v, input int pf, input int ps, input bit last);
    mcd_pkg::in_item_t it;
    it.vertex = mcd_pkg::VERT_W'(v);
    it.partner_first = mcd_pkg::VERT_W'(pf);
    it.partner_second = mcd_pkg::VERT_W'(ps);
    it.last = last;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.note_item(it);
    if (v < VERTICES || last) loaded_items++;
  endtask

  function automatic void shuffle(inout int a[VERTICES]);
    int j, t;
    for (int i = VERTICES - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = a[i];
      a[i] = a[j];
      a[j] = t;
    end
  endfunction

  function automatic void make_matching(output int m[VERTICES]);
    int p[VERTICES];
    for (int i = 0; i < VERTICES; i++) p[i] = i;
    shuffle(p);
    for (int i = 0; i < VERTICES; i += 2) begin
      m[p[i]] = p[i+1];
      m[p[i+1]] = p[i];
    end
  endfunction

  function automatic int pick_vertex();
    return ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(VERTICES - 1);
  endfunction

  initial begin
    int fm[VERTICES];
    int sm[VERTICES];
    int order[VERTICES];
    int kind, count, bad, start;
    book = new();
    send_idle_pct = 38;
    recv_idle_pct = 63;
    loaded_items = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_ready <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int v = 0; v < VERTICES; v++) send_item(v, v ^ 1, v ^ 1, v == VERTICES - 1);
    send_item(31, 31, 31, 1'b1);
    send_item(0, 31, 0, 1'b1);
    send_item(16, 17, 0, 1'b0);
    send_item(17, 16, 1, 1'b0);
    send_item(1, 0, 17, 1'b0);
    send_item(0, 1, 16, 1'b1);

    start = loaded_items;
    while (loaded_items - start < RANDOM_ITEMS) begin
      if (loaded_items - start < RANDOM_ITEMS / 3) begin
        send_idle_pct = 38;
        recv_idle_pct = 63;
      end else if (loaded_items - start < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 63;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      kind = $urandom_range(99);
      if (kind < 80) begin
        make_matching(fm);
        make_matching(sm);
        if (kind >= 65) begin
          bad = $urandom_range(VERTICES - 1);
          if ($urandom_range(1)) fm[bad] = $urandom_range(31);
          else sm[bad] = $urandom_range(31);
        end
        for (int i = 0; i < VERTICES; i++) order[i] = i;
        shuffle(order);
        for (int i = 0; i < VERTICES; i++) begin
          send_item(order[i], fm[order[i]], sm[order[i]], i == VERTICES - 1);
        end
      end else begin
        count = $urandom_range(1, 3);
        for (int i = 0; i < count; i++) begin
          send_item(pick_vertex(), pick_vertex(), pick_vertex(), i == count - 1);
        end
      end
    end

    in_valid <= 1'b0;
    while (book.walk_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (book.fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
